>>> rtl/core/pgmp_pkg.sv
// Shared types, codes and helpers for the PGM ASCII stream parser.
`timescale 1ns / 1ps

package pgmp_pkg;

    localparam logic [7:0]  COMMENT_CH = 8'h23;
    localparam logic [7:0]  LINE_FEED  = 8'h0A;
    localparam logic [7:0]  SPACE_CH   = 8'h20;
    localparam logic [7:0]  TAB_CH     = 8'h09;
    localparam logic [7:0]  CR_CH      = 8'h0D;
    localparam logic [7:0]  ZERO_CH    = 8'h30;
    localparam logic [7:0]  NINE_CH    = 8'h39;
    localparam logic [15:0] SAT_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_WS_PRE  = 3'd0,
        PH_CMT_PRE = 3'd1,
        PH_MAGIC2  = 3'd2,
        PH_WS      = 3'd3,
        PH_CMT     = 3'd4,
        PH_TOKEN   = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        FLD_WIDTH  = 2'd0,
        FLD_HEIGHT = 2'd1,
        FLD_MAXVAL = 2'd2,
        FLD_PIXEL  = 2'd3
    } t_field;

    typedef enum logic [2:0] {
        KIND_MAGIC  = 3'd0,
        KIND_WIDTH  = 3'd1,
        KIND_HEIGHT = 3'd2,
        KIND_MAXVAL = 3'd3,
        KIND_PIXEL  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [15:0] row;
        logic [15:0] col;
        logic        last;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == SPACE_CH) || ((b >= TAB_CH) && (b <= CR_CH));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ZERO_CH) && (b <= NINE_CH);
    endfunction

endpackage

>>> rtl/core/pgm_ascii_stream_parser_top.sv
// Top level: PGM ASCII parser with output register and skid stage.
// Results are registered in the output register, or in the skid stage on stall.
// One byte per cycle unless stalled; the parser step is one registered pass.
// Input stall rises only while the skid stage holds a second result.
// Reset is synchronous, active low: parser state restarts, output and skid empty.
`timescale 1ns / 1ps

module pgm_ascii_stream_parser_top import pgmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_token_value,
    output logic [15:0] o_pixel_row,
    output logic [15:0] o_pixel_col,
    output logic        o_last_pixel
);

    logic    beat;
    logic    res_valid;
    t_result res;
    logic    out_take;

    logic    r_out_valid, n_out_valid;
    t_result r_out,       n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid,      n_skid;

    assign beat = i_in_valid && !o_in_stall;

    pgmp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (beat),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_end_of_file (i_end_of_file),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    assign out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out       = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_token_kind  = r_out.kind;
    assign o_token_value = r_out.value;
    assign o_pixel_row   = r_out.row;
    assign o_pixel_col   = r_out.col;
    assign o_last_pixel  = r_out.last;

    a_no_res_while_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_skid_valid)
        else $error("parser result while skid stage full");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat with output register empty");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.kind == KIND_PIXEL))
        else $error("last pixel flag on a header token");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !res_valid) |=> !r_out_valid)
        else $error("output beat without a parser result");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output beat changed");

endmodule

>>> rtl/core/pgmp_parse.sv
// Parser state registers and the per-byte next-state and token logic.
`timescale 1ns / 1ps

module pgmp_parse import pgmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_beat,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_end_of_file,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase,  n_phase;
    t_field      r_field,  n_field;
    logic [15:0] r_accum,  n_accum;
    logic        r_stop,   n_stop;
    logic [7:0]  r_magic,  n_magic;
    logic [15:0] r_width,  n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_row,    n_row;
    logic [15:0] r_col,    n_col;

    t_phase      c_phase;
    t_field      c_field;
    logic [15:0] c_accum;
    logic        c_stop;
    logic [7:0]  c_magic;
    logic [15:0] c_width;
    logic [15:0] c_height;
    logic [15:0] c_row;
    logic [15:0] c_col;

    logic [15:0] base_accum;
    logic        base_stop;
    logic [19:0] mac;
    logic [15:0] fed_accum;
    logic        fed_stop;
    logic        do_finish;
    logic [15:0] fin_val;
    logic        last_col;
    logic        last_all;
    logic        emit;
    t_result     res;

    always_comb begin
        // frame start restarts the parser before this byte is used
        c_phase  = i_frame_start ? PH_WS_PRE : r_phase;
        c_field  = i_frame_start ? FLD_WIDTH : r_field;
        c_accum  = i_frame_start ? 16'd0 : r_accum;
        c_stop   = i_frame_start ? 1'b0  : r_stop;
        c_magic  = i_frame_start ? 8'd0  : r_magic;
        c_width  = i_frame_start ? 16'd0 : r_width;
        c_height = i_frame_start ? 16'd0 : r_height;
        c_row    = i_frame_start ? 16'd0 : r_row;
        c_col    = i_frame_start ? 16'd0 : r_col;

        // digit accumulate, x10 as shift-add, saturating
        base_accum = (c_phase == PH_WS) ? 16'd0 : c_accum;
        base_stop  = (c_phase == PH_WS) ? 1'b0  : c_stop;
        mac = ({4'd0, base_accum} << 3) + ({4'd0, base_accum} << 1)
            + {12'd0, i_data_byte - ZERO_CH};
        fed_accum = base_accum;
        fed_stop  = base_stop;
        if (!base_stop) begin
            if (is_digit(i_data_byte)) begin
                fed_accum = (mac[19:16] != 4'd0) ? SAT_MAX : mac[15:0];
            end else begin
                fed_stop = 1'b1;
            end
        end

        n_phase  = c_phase;
        n_field  = c_field;
        n_accum  = c_accum;
        n_stop   = c_stop;
        n_magic  = c_magic;
        n_width  = c_width;
        n_height = c_height;
        n_row    = c_row;
        n_col    = c_col;
        do_finish = 1'b0;
        fin_val   = fed_accum;
        emit      = 1'b0;
        res       = '{kind: KIND_MAGIC, value: 16'd0, row: 16'd0, col: 16'd0, last: 1'b0};

        case (c_phase)
            PH_WS_PRE: begin
                if (is_ws(i_data_byte)) begin
                end else if (i_data_byte == COMMENT_CH) begin
                    n_phase = PH_CMT_PRE;
                end else begin
                    n_magic = i_data_byte;
                    n_phase = PH_MAGIC2;
                    if (i_end_of_file) begin
                        emit      = 1'b1;
                        res.value = {i_data_byte, 8'd0};
                    end
                end
            end
            PH_CMT_PRE: begin
                if (i_data_byte == LINE_FEED) begin
                    n_phase = PH_WS_PRE;
                end
            end
            PH_MAGIC2: begin
                emit      = 1'b1;
                res.value = {c_magic, i_data_byte};
                n_field   = FLD_WIDTH;
                n_phase   = PH_WS;
            end
            PH_WS: begin
                if (is_ws(i_data_byte)) begin
                end else if (i_data_byte == COMMENT_CH) begin
                    n_phase = PH_CMT;
                end else begin
                    n_accum   = fed_accum;
                    n_stop    = fed_stop;
                    n_phase   = PH_TOKEN;
                    do_finish = i_end_of_file;
                end
            end
            PH_CMT: begin
                if (i_data_byte == LINE_FEED) begin
                    n_phase = PH_WS;
                end
            end
            PH_TOKEN: begin
                if (is_ws(i_data_byte)) begin
                    do_finish = 1'b1;
                    fin_val   = c_accum;
                end else begin
                    n_accum   = fed_accum;
                    n_stop    = fed_stop;
                    do_finish = i_end_of_file;
                end
            end
            default: begin
            end
        endcase

        last_col = ({1'b0, c_col} + 17'd1) >= {1'b0, c_width};
        last_all = last_col && (({1'b0, c_row} + 17'd1) >= {1'b0, c_height});

        if (do_finish) begin
            emit      = 1'b1;
            n_phase   = PH_WS;
            res.value = fin_val;
            case (c_field)
                FLD_WIDTH: begin
                    n_width  = fin_val;
                    res.kind = KIND_WIDTH;
                    n_field  = FLD_HEIGHT;
                end
                FLD_HEIGHT: begin
                    n_height = fin_val;
                    res.kind = KIND_HEIGHT;
                    n_field  = FLD_MAXVAL;
                end
                FLD_MAXVAL: begin
                    res.kind = KIND_MAXVAL;
                    n_field  = FLD_PIXEL;
                    n_row    = 16'd0;
                    n_col    = 16'd0;
                    if ((c_width == 16'd0) || (c_height == 16'd0)) begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    res.kind  = KIND_PIXEL;
                    res.value = {8'd0, fin_val[7:0]};
                    res.row   = c_row;
                    res.col   = c_col;
                    res.last  = last_all;
                    if (last_all) begin
                        n_phase = PH_DONE;
                    end else if (last_col) begin
                        n_col = 16'd0;
                        n_row = c_row + 16'd1;
                    end else begin
                        n_col = c_col + 16'd1;
                    end
                end
            endcase
        end

        if (i_end_of_file) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WS_PRE;
            r_field  <= FLD_WIDTH;
            r_accum  <= 16'd0;
            r_stop   <= 1'b0;
            r_magic  <= 8'd0;
            r_width  <= 16'd0;
            r_height <= 16'd0;
            r_row    <= 16'd0;
            r_col    <= 16'd0;
        end else if (i_beat) begin
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_accum  <= n_accum;
            r_stop   <= n_stop;
            r_magic  <= n_magic;
            r_width  <= n_width;
            r_height <= n_height;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

    assign o_res_valid = i_beat && emit;
    assign o_res       = res;

endmodule
